// ===== rtl/pbc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared constants, types and command/status structs for the point bin chainer.
// ----------------------------------------------------------------------------
`default_nettype none

package pbc_pkg;

    // Sizes of the bin table and of the point counter.
    localparam int BIN_CAPACITY = 262144;
    localparam int MAX_POINTS   = 1048576;
    localparam int BIN_W        = $clog2(BIN_CAPACITY);
    localparam int PIDX_W       = 20;
    localparam int CNT_W        = $clog2(MAX_POINTS) + 1;

    // Field widths.
    localparam int DEG_W     = 26;
    localparam int NLON_W    = 10;
    localparam int NLAT_W    = 9;
    localparam int WLON_W    = 25;
    localparam int WLAT_W    = 24;
    localparam int CFG_W     = 25;

    // Divider geometry: 26-bit magnitude over a 25-bit divisor.
    localparam int DIV_N_W   = 26;
    localparam int DIV_D_W   = 25;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Epoch mark kept next to each tail entry.
    localparam int EPOCH_W   = 8;
    localparam int WORD_W    = EPOCH_W + PIDX_W;

    // 90 degrees with 16 fraction bits.
    localparam int LAT_OFFSET = 90 * 65536;

    // Register indexes.
    typedef enum logic [1:0] {
        REG_LON_BINS  = 2'd0,
        REG_LAT_BINS  = 2'd1,
        REG_LON_WIDTH = 2'd2,
        REG_LAT_WIDTH = 2'd3
    } pbc_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR_RST,
        ST_IDLE,
        ST_CLEAR_START,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_BIN,
        ST_READ,
        ST_EMIT
    } pbc_state_t;

    typedef struct packed {
        logic load;
        logic div_go;
        logic mod_go;
        logic bin_load;
        logic mem_read;
        logic emit;
        logic clear_step;
        logic clear_done;
    } pbc_cmd_t;

    typedef struct packed {
        logic wrap_on_load;
        logic div_done;
        logic mod_done;
        logic clear_last;
        logic out_free;
    } pbc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/point_bin_chainer.sv =====
// ----------------------------------------------------------------------------
// point_bin_chainer
// Bins latitude/longitude points and chains the points of each bin.
// ----------------------------------------------------------------------------
//  Port group | Dir | Handshake         | Content
//  s_*        | in  | s_valid / s_ready | lon_deg, lat_deg, start_new
//  m_*        | out | m_valid / m_ready | point_index, bin_index, starts_bin,
//             |     |                   | previous_point, overflow
//  cfg_*      | in  | cfg_we            | cfg_index, cfg_data
//
// Each point passes through two rounds of 26-step division (the floor
// divisions of both coordinates side by side, then the longitude modulo), then
// one table read and write. No new point is accepted until the last is done.
// After reset a clearing pass sweeps the tail table; the same
// pass runs on every 255th start_new, when the 8-bit epoch mark wraps.
// The result register holds a finished result while the next point is accepted;
// a stalled output only holds the block at the final table update.
// ----------------------------------------------------------------------------
`default_nettype none

module point_bin_chainer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [pbc_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [pbc_pkg::DEG_W-1:0]  s_lon_deg,
    input  wire logic signed [pbc_pkg::DEG_W-1:0]  s_lat_deg,
    input  wire logic                              s_start_new,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [pbc_pkg::PIDX_W-1:0]             m_point_index,
    output logic [pbc_pkg::BIN_W-1:0]              m_bin_index,
    output logic                                   m_starts_bin,
    output logic [pbc_pkg::PIDX_W-1:0]             m_previous_point,
    output logic                                   m_overflow
);
    import pbc_pkg::*;

    pbc_cmd_t cmd;
    pbc_sts_t sts;

    pbc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .sts(sts), .cmd(cmd)
    );

    pbc_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_lon_deg(s_lon_deg), .s_lat_deg(s_lat_deg), .s_start_new(s_start_new),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_point_index(m_point_index), .m_bin_index(m_bin_index),
        .m_starts_bin(m_starts_bin), .m_previous_point(m_previous_point),
        .m_overflow(m_overflow)
    );

endmodule

`default_nettype wire

// ===== rtl/pbc_divider.sv =====
// ----------------------------------------------------------------------------
// pbc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_divider (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [pbc_pkg::DIV_N_W-1:0] num,
    input  wire logic [pbc_pkg::DIV_D_W-1:0] den,
    output logic                             done,
    output logic [pbc_pkg::DIV_N_W-1:0]      quo,
    output logic [pbc_pkg::DIV_D_W-1:0]      rem
);
    import pbc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   work_reg;
    logic [DIV_D_W-1:0]   part_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 ge;

    // One trial subtraction per step.
    always_comb begin
        trial = {part_reg, work_reg[DIV_N_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    // Step control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= num;
            part_reg <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            part_reg <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            work_reg <= {work_reg[DIV_N_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = work_reg;
    assign rem  = part_reg;

endmodule

`default_nettype wire

// ===== rtl/pbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbc_ctrl
// Sequencer for one point: clear sweep, divide, reduce, bin, table update.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pbc_pkg::pbc_sts_t sts,
    output pbc_pkg::pbc_cmd_t      cmd
);
    import pbc_pkg::*;

    pbc_state_t state_reg;
    pbc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR_RST;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR_RST: begin
                if (sts.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = sts.wrap_on_load ? ST_CLEAR_START : ST_DIV_GO;
            end
            ST_CLEAR_START: begin
                if (sts.clear_last) state_next = ST_DIV_GO;
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (sts.div_done) state_next = ST_MOD_GO;
            end
            ST_MOD_GO:   state_next = ST_MOD_WAIT;
            ST_MOD_WAIT: begin
                if (sts.mod_done) state_next = ST_BIN;
            end
            ST_BIN:  state_next = ST_READ;
            ST_READ: state_next = ST_EMIT;
            ST_EMIT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR_RST;
        endcase
    end

    // Commands.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_CLEAR_RST, ST_CLEAR_START: begin
                cmd.clear_step = 1'b1;
                cmd.clear_done = sts.clear_last;
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DIV_GO:   cmd.div_go   = 1'b1;
            ST_MOD_GO:   cmd.mod_go   = 1'b1;
            ST_BIN:      cmd.bin_load = 1'b1;
            ST_READ:     cmd.mem_read = 1'b1;
            ST_EMIT:     cmd.emit     = sts.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pbc_datapath.sv =====
// ----------------------------------------------------------------------------
// pbc_datapath
// Registers, dividers, bin arithmetic, tail table and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_datapath (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire pbc_pkg::pbc_cmd_t          cmd,
    output pbc_pkg::pbc_sts_t               sts,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [pbc_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic signed [pbc_pkg::DEG_W-1:0] s_lon_deg,
    input  wire logic signed [pbc_pkg::DEG_W-1:0] s_lat_deg,
    input  wire logic                       s_start_new,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [pbc_pkg::PIDX_W-1:0]      m_point_index,
    output logic [pbc_pkg::BIN_W-1:0]       m_bin_index,
    output logic                            m_starts_bin,
    output logic [pbc_pkg::PIDX_W-1:0]      m_previous_point,
    output logic                            m_overflow
);
    import pbc_pkg::*;

    // Configuration registers.
    logic [NLON_W-1:0] lon_bins_reg;
    logic [NLAT_W-1:0] lat_bins_reg;
    logic [WLON_W-1:0] lon_width_reg;
    logic [WLAT_W-1:0] lat_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lon_bins_reg  <= NLON_W'(720);
            lat_bins_reg  <= NLAT_W'(360);
            lon_width_reg <= WLON_W'(32768);
            lat_width_reg <= WLAT_W'(32768);
        end else if (cfg_we) begin
            case (pbc_reg_t'(cfg_index))
                REG_LON_BINS:  lon_bins_reg  <= cfg_data[NLON_W-1:0];
                REG_LAT_BINS:  lat_bins_reg  <= cfg_data[NLAT_W-1:0];
                REG_LON_WIDTH: lon_width_reg <= cfg_data[WLON_W-1:0];
                REG_LAT_WIDTH: lat_width_reg <= cfg_data[WLAT_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero count or width acts as one.
    logic [NLON_W-1:0] nlon;
    logic [NLAT_W-1:0] nlat;
    logic [WLON_W-1:0] wlon;
    logic [WLAT_W-1:0] wlat;

    always_comb begin
        nlon = (lon_bins_reg == '0)  ? NLON_W'(1) : lon_bins_reg;
        nlat = (lat_bins_reg == '0)  ? NLAT_W'(1) : lat_bins_reg;
        wlon = (lon_width_reg == '0) ? WLON_W'(1) : lon_width_reg;
        wlat = (lat_width_reg == '0) ? WLAT_W'(1) : lat_width_reg;
    end

    // Input request capture: longitude magnitude and offset latitude.
    logic                 lon_neg_reg;
    logic [DIV_N_W-1:0]   lon_mag_reg;
    logic                 lat_neg_reg;
    logic [DIV_N_W-1:0]   lat_num_reg;
    logic signed [DEG_W:0] lat_sum;
    logic [DEG_W-1:0]     lon_abs;

    always_comb begin
        lat_sum = {s_lat_deg[DEG_W-1], s_lat_deg} + (DEG_W+1)'(LAT_OFFSET);
        lon_abs = s_lon_deg[DEG_W-1] ? DEG_W'(-s_lon_deg) : DEG_W'(s_lon_deg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lon_neg_reg <= s_lon_deg[DEG_W-1];
            lon_mag_reg <= lon_abs;
            lat_neg_reg <= lat_sum[DEG_W];
            lat_num_reg <= lat_sum[DEG_W-1:0];
        end
    end

    // Epoch mark and point counter.
    logic [EPOCH_W-1:0] epoch_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               epoch_full;
    logic               ovf;

    assign epoch_full = (epoch_reg == '1);
    assign ovf        = (count_reg >= CNT_W'(MAX_POINTS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg <= EPOCH_W'(1);
            count_reg <= '0;
        end else begin
            if (cmd.clear_done) begin
                epoch_reg <= EPOCH_W'(1);
            end else if (cmd.load && s_start_new && !epoch_full) begin
                epoch_reg <= epoch_reg + 1'b1;
            end
            if (cmd.load && s_start_new) begin
                count_reg <= '0;
            end else if (cmd.emit && !ovf) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Floor divisions, then the longitude reduction.
    logic               lon_done;
    logic               lat_done;
    logic               mod_done;
    logic [DIV_N_W-1:0] lon_q;
    logic [DIV_D_W-1:0] lon_r;
    logic [DIV_N_W-1:0] lat_q;
    logic [DIV_D_W-1:0] lat_r;
    logic [DIV_N_W-1:0] mod_q;
    logic [DIV_D_W-1:0] mod_r;
    logic [DIV_N_W-1:0] mod_num;

    pbc_divider u_div_lon (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_go),
        .num(lon_mag_reg), .den(wlon),
        .done(lon_done), .quo(lon_q), .rem(lon_r)
    );

    pbc_divider u_div_lat (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_go),
        .num(lat_num_reg), .den(DIV_D_W'(wlat)),
        .done(lat_done), .quo(lat_q), .rem(lat_r)
    );

    // A negative longitude with a remainder rounds one bin further down.
    assign mod_num = lon_q + DIV_N_W'(lon_neg_reg && (lon_r != '0));

    pbc_divider u_div_mod (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.mod_go),
        .num(mod_num), .den(DIV_D_W'(nlon)),
        .done(mod_done), .quo(mod_q), .rem(mod_r)
    );

    // Bin number from the two bin coordinates.
    logic [NLON_W-1:0]        bi;
    logic [NLAT_W-1:0]        bj;
    logic [NLON_W+NLAT_W-1:0] prod;
    logic [NLON_W+NLAT_W:0]   bin_sum;
    logic [BIN_W-1:0]         bin_reg;
    logic                     lat_hi;

    always_comb begin
        if (lon_neg_reg && (mod_r != '0)) begin
            bi = nlon - mod_r[NLON_W-1:0];
        end else begin
            bi = mod_r[NLON_W-1:0];
        end
        lat_hi = (lat_q > DIV_N_W'(nlat - 1'b1));
        if (lat_neg_reg) begin
            bj = '0;
        end else if (lat_hi) begin
            bj = nlat - 1'b1;
        end else begin
            bj = lat_q[NLAT_W-1:0];
        end
        prod    = bi * nlat;
        bin_sum = {1'b0, prod} + (NLON_W+NLAT_W+1)'(bj);
    end

    always_ff @(posedge aclk) begin
        if (cmd.bin_load) begin
            if (bin_sum > (NLON_W+NLAT_W+1)'(BIN_CAPACITY - 1)) begin
                bin_reg <= BIN_W'(BIN_CAPACITY - 1);
            end else begin
                bin_reg <= bin_sum[BIN_W-1:0];
            end
        end
    end

    // Tail table: {epoch, tail} per bin; an entry is live when its epoch matches.
    logic [WORD_W-1:0] mem [BIN_CAPACITY];
    logic [WORD_W-1:0] rd_reg;
    logic [BIN_W-1:0]  clr_addr_reg;
    logic              wr_en;
    logic [BIN_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              live;

    assign live = (rd_reg[WORD_W-1:PIDX_W] == epoch_reg);

    always_comb begin
        if (cmd.clear_step) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end else begin
            wr_en   = cmd.emit && !ovf;
            wr_addr = bin_reg;
            wr_data = {epoch_reg, count_reg[PIDX_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_read) begin
            rd_reg <= mem[bin_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Result register.
    logic              out_valid_reg;
    logic [PIDX_W-1:0] out_pidx_reg;
    logic [BIN_W-1:0]  out_bin_reg;
    logic              out_head_reg;
    logic [PIDX_W-1:0] out_prev_reg;
    logic              out_ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_pidx_reg <= count_reg[PIDX_W-1:0];
            out_bin_reg  <= bin_reg;
            out_head_reg <= !ovf && !live;
            out_prev_reg <= (!ovf && live) ? rd_reg[PIDX_W-1:0] : '0;
            out_ovf_reg  <= ovf;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_point_index    = out_pidx_reg;
    assign m_bin_index      = out_bin_reg;
    assign m_starts_bin     = out_head_reg;
    assign m_previous_point = out_prev_reg;
    assign m_overflow       = out_ovf_reg;

    // Status to the sequencer.
    always_comb begin
        sts.wrap_on_load = s_start_new && epoch_full;
        sts.div_done     = lon_done && lat_done;
        sts.mod_done     = mod_done;
        sts.clear_last   = (clr_addr_reg == '1);
        sts.out_free     = !out_valid_reg || m_ready;
    end

    // The latitude remainder and the modulo quotient are not needed.
    logic unused_bits;
    assign unused_bits = ^{lat_r, mod_q};

endmodule

`default_nettype wire

// ===== rtl/pbc_checker.sv =====
// ----------------------------------------------------------------------------
// pbc_checker
// Port-level checks on the point bin chainer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [pbc_pkg::PIDX_W-1:0]    m_point_index,
    input wire logic                          m_starts_bin,
    input wire logic [pbc_pkg::PIDX_W-1:0]    m_previous_point,
    input wire logic                          m_overflow
);

    // An overflowed point is neither a head nor linked.
    a_ovf_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> !m_starts_bin && (m_previous_point == '0))
        else $error("overflow result carries chain data");

    // A head entry has no previous point.
    a_head_prev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_starts_bin |-> (m_previous_point == '0))
        else $error("head entry with previous point");

    // A link always points back to an earlier point.
    a_link_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_starts_bin && !m_overflow |-> (m_previous_point < m_point_index))
        else $error("link does not point backward");

    // One point at a time: no request is taken right after another.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("back-to-back requests accepted");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_index))
        else $error("stalled result changed");

endmodule

bind point_bin_chainer pbc_checker u_pbc_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_point_index(m_point_index), .m_starts_bin(m_starts_bin),
    .m_previous_point(m_previous_point), .m_overflow(m_overflow)
);

`default_nettype wire
